[sv/box_mesh_trs_transform_defines.svh]
// assertion macros for the box mesh transform
`ifndef BOX_MESH_TRS_TRANSFORM_DEFINES_SVH
`define BOX_MESH_TRS_TRANSFORM_DEFINES_SVH

`ifndef ASSERT_OFF
`define BMT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMT_ASSERT(lbl, prop, msg) \
  `BMT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define BMT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define BMT_ASSERT(lbl, prop, msg)
`endif

`endif

[sv/bmt_pkg.sv]
package bmt_pkg;

  localparam int VERTS_PER_BOX = 36;
  localparam int CORDIC_STEPS  = 14;
  localparam int ATAN_ENTRIES  = 20;

  localparam int VW = 16;
  localparam int CW = 8;
  localparam int TW = 20;
  localparam int ZW = 20;
  localparam int LW = 2 * TW;

  localparam int STEP_W  = $clog2(CORDIC_STEPS);
  localparam int ATAN_IW = $clog2(ATAN_ENTRIES);
  localparam int VTX_W   = $clog2(VERTS_PER_BOX);

  localparam int MAT_STEPS = 23;
  localparam int MSTEP_W   = $clog2(MAT_STEPS);
  localparam int LIN_BASE  = 14;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [MSTEP_W-1:0] LAST_MSTEP = MSTEP_W'(MAT_STEPS - 1);
  localparam logic [VTX_W-1:0]   LAST_VTX   = VTX_W'(VERTS_PER_BOX - 1);

  localparam logic signed [VW:0]   HALF_PI_Q13     = (VW+1)'(12868);
  localparam logic signed [VW:0]   PI_Q13          = (VW+1)'(25736);
  localparam logic signed [TW-1:0] CORDIC_GAIN_INV = TW'(39797);

  localparam logic signed [LW-1:0] SAT_MAX  = LW'(32767);
  localparam logic signed [LW-1:0] SAT_MIN  = -LW'(32768);
  localparam logic signed [LW-1:0] POS_RND  = LW'(65536);
  localparam logic signed [LW-1:0] NORM_RND = LW'(32768);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic [VW-1:0] val_t;
  typedef logic [CW-1:0] chan_t;
  typedef logic [TW-1:0] tv_t;
  typedef logic [LW-1:0] lv_t;

  typedef struct packed {
    val_t  [2:0] pos;
    val_t  [2:0] scl;
    chan_t [2:0] color;
  } box_t;

  typedef struct packed {
    tv_t [2:0] sn;
    tv_t [2:0] cs;
    box_t      box;
  } sincos_t;

  typedef struct packed {
    lv_t [8:0] lin;
    box_t      box;
  } mat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } stage_e;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [ATAN_IW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(51472);
      5'd1:    v = ZW'(30386);
      5'd2:    v = ZW'(16055);
      5'd3:    v = ZW'(8150);
      5'd4:    v = ZW'(4091);
      5'd5:    v = ZW'(2047);
      5'd6:    v = ZW'(1024);
      5'd7:    v = ZW'(512);
      5'd8:    v = ZW'(256);
      5'd9:    v = ZW'(128);
      5'd10:   v = ZW'(64);
      5'd11:   v = ZW'(32);
      5'd12:   v = ZW'(16);
      5'd13:   v = ZW'(8);
      5'd14:   v = ZW'(4);
      5'd15:   v = ZW'(2);
      5'd16:   v = ZW'(1);
      5'd17:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // {pos sign x,y,z (1 = plus), normal axis, normal negative, u, v}
  function automatic logic [7:0] cube_row(input logic [VTX_W-1:0] k);
    logic [7:0] r;
    case (k)
      6'd0:    r = 8'b000_10_1_00;
      6'd1:    r = 8'b100_10_1_10;
      6'd2:    r = 8'b110_10_1_11;
      6'd3:    r = 8'b110_10_1_11;
      6'd4:    r = 8'b010_10_1_01;
      6'd5:    r = 8'b000_10_1_00;
      6'd6:    r = 8'b001_10_0_00;
      6'd7:    r = 8'b101_10_0_10;
      6'd8:    r = 8'b111_10_0_11;
      6'd9:    r = 8'b111_10_0_11;
      6'd10:   r = 8'b011_10_0_01;
      6'd11:   r = 8'b001_10_0_00;
      6'd12:   r = 8'b011_00_1_10;
      6'd13:   r = 8'b010_00_1_11;
      6'd14:   r = 8'b000_00_1_01;
      6'd15:   r = 8'b000_00_1_01;
      6'd16:   r = 8'b001_00_1_00;
      6'd17:   r = 8'b011_00_1_10;
      6'd18:   r = 8'b111_00_0_10;
      6'd19:   r = 8'b110_00_0_11;
      6'd20:   r = 8'b100_00_0_01;
      6'd21:   r = 8'b100_00_0_01;
      6'd22:   r = 8'b101_00_0_00;
      6'd23:   r = 8'b111_00_0_10;
      6'd24:   r = 8'b000_01_1_01;
      6'd25:   r = 8'b100_01_1_11;
      6'd26:   r = 8'b101_01_1_10;
      6'd27:   r = 8'b101_01_1_10;
      6'd28:   r = 8'b001_01_1_00;
      6'd29:   r = 8'b000_01_1_01;
      6'd30:   r = 8'b010_01_0_01;
      6'd31:   r = 8'b110_01_0_11;
      6'd32:   r = 8'b111_01_0_10;
      6'd33:   r = 8'b111_01_0_10;
      6'd34:   r = 8'b011_01_0_00;
      6'd35:   r = 8'b010_01_0_01;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic val_t sat16(input logic signed [LW-1:0] v);
    val_t r;
    if (v > SAT_MAX) r = VW'(SAT_MAX);
    else if (v < SAT_MIN) r = VW'(SAT_MIN);
    else r = VW'(v);
    return r;
  endfunction

endpackage

[sv/bmt_cordic.sv]
module bmt_cordic import bmt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  val_t [2:0] angle_i,
  input  box_t       box_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output sincos_t    out_o
);

  stage_e state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic take;

  logic signed [TW-1:0] x_q [3];
  logic signed [TW-1:0] y_q [3];
  logic signed [ZW-1:0] z_q [3];
  logic signed [TW-1:0] x_d [3];
  logic signed [TW-1:0] y_d [3];
  logic signed [ZW-1:0] z_d [3];
  logic signed [ZW-1:0] z_in [3];
  logic signed [VW:0]   a_ext [3];
  logic signed [VW:0]   a_red [3];
  logic                 neg_in [3];
  logic                 neg_q [3];
  logic signed [ZW-1:0] atan_v;
  box_t box_q;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (step_q == LAST_STEP) state_d = ST_DONE;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) state_d = in_valid_i ? ST_RUN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign take   = in_valid_i && in_ready_o;
  assign atan_v = atan_q16(ATAN_IW'(step_q));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      a_ext[a]  = {angle_i[a][VW-1], angle_i[a]};
      a_red[a]  = a_ext[a];
      neg_in[a] = 1'b0;
      if (a_ext[a] > HALF_PI_Q13) begin
        a_red[a]  = a_ext[a] - PI_Q13;
        neg_in[a] = 1'b1;
      end else if (a_ext[a] < -HALF_PI_Q13) begin
        a_red[a]  = a_ext[a] + PI_Q13;
        neg_in[a] = 1'b1;
      end
      z_in[a] = ZW'(a_red[a]) <<< 3;
      if (!z_q[a][ZW-1]) begin
        x_d[a] = x_q[a] - (y_q[a] >>> step_q);
        y_d[a] = y_q[a] + (x_q[a] >>> step_q);
        z_d[a] = z_q[a] - atan_v;
      end else begin
        x_d[a] = x_q[a] + (y_q[a] >>> step_q);
        y_d[a] = y_q[a] - (x_q[a] >>> step_q);
        z_d[a] = z_q[a] + atan_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (take) step_q <= '0;
      else if (state_q == ST_RUN) step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      box_q <= box_i;
      for (int a = 0; a < 3; a++) begin
        x_q[a]   <= CORDIC_GAIN_INV;
        y_q[a]   <= '0;
        z_q[a]   <= z_in[a];
        neg_q[a] <= neg_in[a];
      end
    end else if (state_q == ST_RUN) begin
      for (int a = 0; a < 3; a++) begin
        x_q[a] <= x_d[a];
        y_q[a] <= y_d[a];
        z_q[a] <= z_d[a];
      end
    end
  end

  always_comb begin
    out_o.box = box_q;
    for (int a = 0; a < 3; a++) begin
      out_o.cs[a] = neg_q[a] ? -x_q[a] : x_q[a];
      out_o.sn[a] = neg_q[a] ? -y_q[a] : y_q[a];
    end
  end

endmodule

[sv/bmt_matrix.sv]
module bmt_matrix import bmt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sincos_t in_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output mat_t    out_o
);

  stage_e state_q, state_d;
  logic [MSTEP_W-1:0] step_q;
  logic take;
  sincos_t sc_q;

  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;
  logic signed [TW-1:0] ta_q, tb_q, tp_q;
  logic signed [TW-1:0] r_q [9];
  logic signed [LW-1:0] l_q [9];
  logic signed [TW-1:0] op_a, op_b, q;
  logic signed [LW-1:0] prod;
  logic [3:0] lidx;
  logic [1:0] lcol;
  logic [VW-1:0] scl_sel;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (step_q == LAST_MSTEP) state_d = ST_DONE;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) state_d = in_valid_i ? ST_RUN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign take = in_valid_i && in_ready_o;

  assign sx = $signed(sc_q.sn[0]);
  assign sy = $signed(sc_q.sn[1]);
  assign sz = $signed(sc_q.sn[2]);
  assign cx = $signed(sc_q.cs[0]);
  assign cy = $signed(sc_q.cs[1]);
  assign cz = $signed(sc_q.cs[2]);

  assign lidx = 4'(step_q - MSTEP_W'(LIN_BASE));

  always_comb begin
    case (lidx)
      4'd0, 4'd3, 4'd6: lcol = AXIS_X;
      4'd1, 4'd4, 4'd7: lcol = AXIS_Y;
      default:          lcol = AXIS_Z;
    endcase
    scl_sel = sc_q.box.scl[lcol];
  end

  // rotation products first, then the scaled linear part
  always_comb begin
    case (step_q)
      5'd0:    begin op_a = cz;   op_b = cy; end
      5'd1:    begin op_a = cz;   op_b = sy; end
      5'd2:    begin op_a = sz;   op_b = sy; end
      5'd3:    begin op_a = ta_q; op_b = sx; end
      5'd4:    begin op_a = sz;   op_b = cx; end
      5'd5:    begin op_a = ta_q; op_b = cx; end
      5'd6:    begin op_a = sz;   op_b = sx; end
      5'd7:    begin op_a = sz;   op_b = cy; end
      5'd8:    begin op_a = tb_q; op_b = sx; end
      5'd9:    begin op_a = cz;   op_b = cx; end
      5'd10:   begin op_a = tb_q; op_b = cx; end
      5'd11:   begin op_a = cz;   op_b = sx; end
      5'd12:   begin op_a = cy;   op_b = sx; end
      5'd13:   begin op_a = cy;   op_b = cx; end
      default: begin
        op_a = (lidx < 4'd9) ? r_q[lidx] : '0;
        op_b = {{(TW-VW){scl_sel[VW-1]}}, scl_sel};
      end
    endcase
    prod = op_a * op_b;
    q    = TW'(prod >>> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (take) step_q <= '0;
      else if (state_q == ST_RUN) step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sc_q <= in_i;
    end else if (state_q == ST_RUN) begin
      case (step_q)
        5'd0:  r_q[0] <= q;
        5'd1:  ta_q   <= q;
        5'd2:  tb_q   <= q;
        5'd3:  tp_q   <= q;
        5'd4:  r_q[1] <= tp_q - q;
        5'd5:  tp_q   <= q;
        5'd6:  r_q[2] <= tp_q + q;
        5'd7:  r_q[3] <= q;
        5'd8:  tp_q   <= q;
        5'd9:  r_q[4] <= tp_q + q;
        5'd10: tp_q   <= q;
        5'd11: r_q[5] <= tp_q - q;
        5'd12: r_q[7] <= q;
        5'd13: begin
          r_q[8] <= q;
          r_q[6] <= -sy;
        end
        default: begin
          if (lidx < 4'd9) l_q[lidx] <= prod;
        end
      endcase
    end
  end

  always_comb begin
    out_o.box = sc_q.box;
    for (int i = 0; i < 9; i++) out_o.lin[i] = l_q[i];
  end

endmodule

[sv/bmt_queue.sv]
module bmt_queue import bmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  mat_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output mat_t out_o
);

  mat_t mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != QCNT_W'(Q_DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_o       = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_i;
  end

endmodule

[sv/bmt_back.sv]
`include "box_mesh_trs_transform_defines.svh"

module bmt_back import bmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  mat_t        in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output val_t  [2:0] pos_o,
  output chan_t [2:0] color_o,
  output logic        tex_u_o,
  output logic        tex_v_o,
  output val_t  [2:0] norm_o,
  output logic        last_o
);

  logic [VTX_W-1:0] k_q;
  logic out_valid_q;
  logic load;
  logic [7:0] row;
  logic [1:0] naxis;

  logic signed [LW-1:0] lin [9];
  logic signed [LW-1:0] acc [3];
  logic signed [LW-1:0] nl  [3];
  logic signed [LW-1:0] pv  [3];
  val_t [2:0] pos_d, norm_d;
  val_t [2:0] pos_q, norm_q;
  chan_t [2:0] color_q;
  logic u_q, v_q, last_q;

  assign load       = in_valid_i && (!out_valid_q || out_ready_i);
  assign in_ready_o = load && (k_q == LAST_VTX);
  assign row        = cube_row(k_q);
  assign naxis      = row[4:3];

  always_comb begin
    for (int i = 0; i < 9; i++) lin[i] = $signed(in_i.lin[i]);
    for (int r = 0; r < 3; r++) begin
      acc[r] = (row[7] ? lin[3*r] : -lin[3*r])
             + (row[6] ? lin[3*r+1] : -lin[3*r+1])
             + (row[5] ? lin[3*r+2] : -lin[3*r+2]);
      pv[r]  = ((acc[r] + POS_RND) >>> 17) + LW'($signed(in_i.box.pos[r]));
      pos_d[r] = sat16(pv[r]);
      nl[r] = lin[4'(3*r) + 4'(naxis)];
      if (row[2]) nl[r] = -nl[r];
      norm_d[r] = sat16((nl[r] + NORM_RND) >>> 16);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        k_q <= (k_q == LAST_VTX) ? '0 : k_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pos_q   <= pos_d;
      norm_q  <= norm_d;
      color_q <= in_i.box.color;
      u_q     <= row[1];
      v_q     <= row[0];
      last_q  <= k_q == LAST_VTX;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_o       = pos_q;
  assign norm_o      = norm_q;
  assign color_o     = color_q;
  assign tex_u_o     = u_q;
  assign tex_v_o     = v_q;
  assign last_o      = last_q;

  `BMT_ASSERT(a_pop_on_last, in_ready_o |-> (k_q == LAST_VTX), "box released before last vertex")
  `BMT_ASSERT(a_box_held, (k_q != '0) |-> in_valid_i, "box lost in the middle of its vertices")
  `BMT_ASSERT(a_last_flag, (load && (k_q == LAST_VTX)) |=> (last_o && out_valid_o), "last flag missing")

endmodule

[sv/box_mesh_trs_transform.sv]
// Box mesh transform: each accepted box (center, size, three Q3.13 angles,
// color) yields 36 cube vertices with position and normal transformed by
// T*Rz*Ry*Rx*S, saturated Q8.8. Boxes are taken back to back, limited by the
// single vertex output (one vertex per transfer). A box passes a CORDIC
// stage, a matrix stage on one shared multiplier and a two-entry queue
// before its vertices start.
module box_mesh_trs_transform import bmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pos_z_i,
  input  logic [15:0] scale_x_i,
  input  logic [15:0] scale_y_i,
  input  logic [15:0] scale_z_i,
  input  logic [15:0] angle_x_i,
  input  logic [15:0] angle_y_i,
  input  logic [15:0] angle_z_i,
  input  logic [7:0]  color_red_i,
  input  logic [7:0]  color_green_i,
  input  logic [7:0]  color_blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic [15:0] out_z_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        tex_u_o,
  output logic        tex_v_o,
  output logic [15:0] norm_x_o,
  output logic [15:0] norm_y_o,
  output logic [15:0] norm_z_o,
  output logic        last_vertex_o
);

  box_t box;
  val_t [2:0] angles;
  sincos_t sc;
  mat_t mat, qmat;
  logic sc_valid, sc_ready, mat_valid, mat_ready, q_valid, q_ready;
  val_t [2:0] pos, norm;
  chan_t [2:0] color;

  assign box.pos   = {pos_z_i, pos_y_i, pos_x_i};
  assign box.scl   = {scale_z_i, scale_y_i, scale_x_i};
  assign box.color = {color_blue_i, color_green_i, color_red_i};
  assign angles    = {angle_z_i, angle_y_i, angle_x_i};

  bmt_cordic u_cordic (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .angle_i     (angles),
    .box_i       (box),
    .out_valid_o (sc_valid),
    .out_ready_i (sc_ready),
    .out_o       (sc)
  );

  bmt_matrix u_matrix (
    .clk_i, .rst_ni,
    .in_valid_i  (sc_valid),
    .in_ready_o  (sc_ready),
    .in_i        (sc),
    .out_valid_o (mat_valid),
    .out_ready_i (mat_ready),
    .out_o       (mat)
  );

  bmt_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i  (mat_valid),
    .in_ready_o  (mat_ready),
    .in_i        (mat),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_o       (qmat)
  );

  bmt_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_i        (qmat),
    .out_valid_o,
    .out_ready_i,
    .pos_o       (pos),
    .color_o     (color),
    .tex_u_o,
    .tex_v_o,
    .norm_o      (norm),
    .last_o      (last_vertex_o)
  );

  assign out_x_o     = pos[0];
  assign out_y_o     = pos[1];
  assign out_z_o     = pos[2];
  assign norm_x_o    = norm[0];
  assign norm_y_o    = norm[1];
  assign norm_z_o    = norm[2];
  assign out_red_o   = color[0];
  assign out_green_o = color[1];
  assign out_blue_o  = color[2];

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import bmt_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_RANDOM   = 240;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [15:0] pos [3];
    logic [15:0] scl [3];
    logic [15:0] ang [3];
    logic [7:0]  col [3];
  } box_item_t;

  typedef struct {
    logic [15:0] x, y, z;
    logic [7:0]  red, green, blue;
    logic        u, v;
    logic [15:0] nx, ny, nz;
    logic        last;
  } vertex_item_t;

  // position signs x y z, normal x y z, u, v
  localparam int CUBE [36][8] = '{
    '{-1,-1,-1, 0, 0,-1, 0,0}, '{ 1,-1,-1, 0, 0,-1, 1,0}, '{ 1, 1,-1, 0, 0,-1, 1,1},
    '{ 1, 1,-1, 0, 0,-1, 1,1}, '{-1, 1,-1, 0, 0,-1, 0,1}, '{-1,-1,-1, 0, 0,-1, 0,0},
    '{-1,-1, 1, 0, 0, 1, 0,0}, '{ 1,-1, 1, 0, 0, 1, 1,0}, '{ 1, 1, 1, 0, 0, 1, 1,1},
    '{ 1, 1, 1, 0, 0, 1, 1,1}, '{-1, 1, 1, 0, 0, 1, 0,1}, '{-1,-1, 1, 0, 0, 1, 0,0},
    '{-1, 1, 1,-1, 0, 0, 1,0}, '{-1, 1,-1,-1, 0, 0, 1,1}, '{-1,-1,-1,-1, 0, 0, 0,1},
    '{-1,-1,-1,-1, 0, 0, 0,1}, '{-1,-1, 1,-1, 0, 0, 0,0}, '{-1, 1, 1,-1, 0, 0, 1,0},
    '{ 1, 1, 1, 1, 0, 0, 1,0}, '{ 1, 1,-1, 1, 0, 0, 1,1}, '{ 1,-1,-1, 1, 0, 0, 0,1},
    '{ 1,-1,-1, 1, 0, 0, 0,1}, '{ 1,-1, 1, 1, 0, 0, 0,0}, '{ 1, 1, 1, 1, 0, 0, 1,0},
    '{-1,-1,-1, 0,-1, 0, 0,1}, '{ 1,-1,-1, 0,-1, 0, 1,1}, '{ 1,-1, 1, 0,-1, 0, 1,0},
    '{ 1,-1, 1, 0,-1, 0, 1,0}, '{-1,-1, 1, 0,-1, 0, 0,0}, '{-1,-1,-1, 0,-1, 0, 0,1},
    '{-1, 1,-1, 0, 1, 0, 0,1}, '{ 1, 1,-1, 0, 1, 0, 1,1}, '{ 1, 1, 1, 0, 1, 0, 1,0},
    '{ 1, 1, 1, 0, 1, 0, 1,0}, '{-1, 1, 1, 0, 1, 0, 0,0}, '{-1, 1,-1, 0, 1, 0, 0,1}
  };

  localparam longint ARCTAN [20] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
    64, 32, 16, 8, 4, 2, 1, 1, 0, 0
  };

  class vertex_scoreboard;
    vertex_item_t expected_q[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint mul_q16(longint a, longint b);
      return (a * b) >>> 16;
    endfunction

    function void sin_cos(longint a, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit     flip;
      flip = 0;
      x = 39797;
      y = 0;
      if (a > 12868) begin
        a -= 25736;
        flip = 1;
      end else if (a < -12868) begin
        a += 25736;
        flip = 1;
      end
      z = a * 8;
      for (int i = 0; i < CORDIC_STEPS && i < 20; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ARCTAN[i];
        end else begin
          x += dx; y -= dy; z += ARCTAN[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void note_box(box_item_t b);
      longint sx, cx, sy, cy, sz, cz;
      longint rot [3][3];
      longint lin [3][3];
      longint acc, nacc;
      vertex_item_t vx;
      sin_cos(longint'($signed(b.ang[0])), sx, cx);
      sin_cos(longint'($signed(b.ang[1])), sy, cy);
      sin_cos(longint'($signed(b.ang[2])), sz, cz);
      rot[0][0] = mul_q16(cz, cy);
      rot[0][1] = mul_q16(mul_q16(cz, sy), sx) - mul_q16(sz, cx);
      rot[0][2] = mul_q16(mul_q16(cz, sy), cx) + mul_q16(sz, sx);
      rot[1][0] = mul_q16(sz, cy);
      rot[1][1] = mul_q16(mul_q16(sz, sy), sx) + mul_q16(cz, cx);
      rot[1][2] = mul_q16(mul_q16(sz, sy), cx) - mul_q16(cz, sx);
      rot[2][0] = -sy;
      rot[2][1] = mul_q16(cy, sx);
      rot[2][2] = mul_q16(cy, cx);
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          lin[r][c] = rot[r][c] * longint'($signed(b.scl[c]));
      for (int k = 0; k < VERTS_PER_BOX; k++) begin
        logic [15:0] p [3];
        logic [15:0] n [3];
        for (int r = 0; r < 3; r++) begin
          acc = 0;
          nacc = 0;
          for (int c = 0; c < 3; c++) begin
            acc += CUBE[k][c] * lin[r][c];
            nacc += CUBE[k][3 + c] * lin[r][c];
          end
          p[r] = 16'(clamp16(longint'($signed(b.pos[r])) + ((acc + 65536) >>> 17)));
          n[r] = 16'(clamp16((nacc + 32768) >>> 16));
        end
        vx.x = p[0]; vx.y = p[1]; vx.z = p[2];
        vx.nx = n[0]; vx.ny = n[1]; vx.nz = n[2];
        vx.red = b.col[0]; vx.green = b.col[1]; vx.blue = b.col[2];
        vx.u = CUBE[k][6][0];
        vx.v = CUBE[k][7][0];
        vx.last = (k == VERTS_PER_BOX - 1);
        expected_q = {expected_q, vx};
      end
    endfunction

    function void compare(string name, longint exp_v, longint act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_vertex(vertex_item_t a);
      vertex_item_t e;
      if (expected_q.size() == 0) begin
        $error("vertex transfer with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("out_x", e.x, a.x);
      compare("out_y", e.y, a.y);
      compare("out_z", e.z, a.z);
      compare("out_red", e.red, a.red);
      compare("out_green", e.green, a.green);
      compare("out_blue", e.blue, a.blue);
      compare("tex_u", e.u, a.u);
      compare("tex_v", e.v, a.v);
      compare("norm_x", e.nx, a.nx);
      compare("norm_y", e.ny, a.ny);
      compare("norm_z", e.nz, a.nz);
      compare("last_vertex", e.last, a.last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [15:0] scale_x_i = '0, scale_y_i = '0, scale_z_i = '0;
  logic [15:0] angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic [7:0]  color_red_i = '0, color_green_i = '0, color_blue_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] out_x_o, out_y_o, out_z_o;
  logic [7:0]  out_red_o, out_green_o, out_blue_o;
  logic        tex_u_o, tex_v_o;
  logic [15:0] norm_x_o, norm_y_o, norm_z_o;
  logic        last_vertex_o;

  vertex_scoreboard sb = new();
  int idle_pct = 22;
  int cycles = 0;

  box_mesh_trs_transform i_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, capture each transfer before its edge
  always @(posedge clk_i)
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= idle_pct);

  always @(negedge clk_i) begin
    vertex_item_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.x = out_x_o; got.y = out_y_o; got.z = out_z_o;
      got.red = out_red_o; got.green = out_green_o; got.blue = out_blue_o;
      got.u = tex_u_o; got.v = tex_v_o;
      got.nx = norm_x_o; got.ny = norm_y_o; got.nz = norm_z_o;
      got.last = last_vertex_o;
      sb.check_vertex(got);
    end
  end

  task automatic send_box(box_item_t b);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= b.pos[0]; pos_y_i <= b.pos[1]; pos_z_i <= b.pos[2];
    scale_x_i <= b.scl[0]; scale_y_i <= b.scl[1]; scale_z_i <= b.scl[2];
    angle_x_i <= b.ang[0]; angle_y_i <= b.ang[1]; angle_z_i <= b.ang[2];
    color_red_i <= b.col[0]; color_green_i <= b.col[1]; color_blue_i <= b.col[2];
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_box(b);
  endtask

  function automatic logic [15:0] pick16(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic box_item_t random_box();
    box_item_t b;
    for (int i = 0; i < 3; i++) begin
      b.pos[i] = ($urandom_range(3) == 0) ? pick16($urandom_range(3)) : 16'($urandom);
      b.scl[i] = ($urandom_range(3) == 0) ? pick16($urandom_range(3)) : pick16(2);
      b.ang[i] = 16'($urandom);
      b.col[i] = 8'($urandom);
    end
    return b;
  endfunction

  function automatic box_item_t make_box(logic [15:0] p, logic [15:0] s, logic [15:0] a,
                                         logic [7:0] c);
    box_item_t b;
    for (int i = 0; i < 3; i++) begin
      b.pos[i] = p; b.scl[i] = s; b.ang[i] = a; b.col[i] = c;
    end
    return b;
  endfunction

  initial begin
    box_item_t b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, reduction boundaries around +-pi/2, degenerate scales
    send_box(make_box(16'h0000, 16'h0100, 16'h0000, 8'h00));
    send_box(make_box(16'h7fff, 16'h7fff, 16'h7fff, 8'hff));
    send_box(make_box(16'h8000, 16'h8000, 16'h8000, 8'h00));
    send_box(make_box(16'h7fff, 16'h8000, 16'h0000, 8'hff));
    send_box(make_box(16'h8000, 16'h7fff, 16'h0000, 8'h55));
    send_box(make_box(16'h0100, 16'h0000, 16'd12868, 8'haa));
    send_box(make_box(16'h0100, 16'h0200, 16'd12869, 8'h0f));
    send_box(make_box(16'hff00, 16'h0200, -16'sd12868, 8'hf0));
    send_box(make_box(16'hff00, 16'h0200, -16'sd12869, 8'h3c));
    send_box(make_box(16'h0000, 16'hff00, 16'd25736, 8'hc3));
    send_box(make_box(16'h0000, 16'h0180, -16'sd25736, 8'h81));
    b = make_box(16'h1234, 16'h0100, 16'h0000, 8'h12);
    b.ang[0] = 16'd6434; b.ang[1] = -16'sd3000; b.ang[2] = 16'd20000;
    b.col[1] = 8'hfe; b.col[2] = 8'h01;
    send_box(b);
    b.scl[0] = 16'h7fff; b.scl[1] = 16'h8000; b.scl[2] = 16'h0000;
    b.pos[0] = 16'h7fff; b.pos[1] = 16'h8000;
    send_box(b);

    // hold off until every vertex has come back
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      idle_pct = (n >= 80 && n < 130) ? 0 : 22;
      send_box(random_box());
    end
    in_valid_i <= 1'b0;
    idle_pct = 22;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/bmt_pkg.sv
sv/bmt_cordic.sv
sv/bmt_matrix.sv
sv/bmt_queue.sv
sv/bmt_back.sv
sv/box_mesh_trs_transform.sv
tb/sv/testbench.sv
